[src/ptfr_pkg.sv]
// ---------------------------------------------------------------------------
// ptfr_pkg
// Shared types and constants of the priority-filtered task ring.
// ---------------------------------------------------------------------------
package ptfr_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int PRIO_SHIFT = 28;
  localparam int WORD_W = 32;
  localparam int PRIO_W = 4;
  localparam int OCC_W = 6;

  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DISPATCHED = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic               is_drain;
    logic [WORD_W-1:0]  dispatch_word;
    logic [WORD_W-1:0]  task_arg;
    logic [PRIO_W-1:0]  threshold;
  } cmd_t;

endpackage

[src/priority_filtered_task_ring.sv]
// ---------------------------------------------------------------------------
// priority_filtered_task_ring
// Circular task ring with enqueue and a priority-filtered scheduling drain.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  input   | in_valid / in_ready   | action, dispatch word, argument, threshold
//  output  | out_valid / out_ready | status, dispatch, argument, occupancy, last
//
// An enqueue is handled by the engine once the output register is free.
// A drain has a start step, a read and a decision step per popped entry,
// a final check step if the ring empties, and a step for the done result.
// The two-entry command queue accepts input while the engine is busy.
// Reset is synchronous; the entry memory is not cleared.
// Each side stalls on its own; the engine waits only when a result is due.
module priority_filtered_task_ring #(
  parameter int SLOTS = ptfr_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [ptfr_pkg::WORD_W-1:0] in_dispatch_word,
  input  logic [ptfr_pkg::WORD_W-1:0] in_task_arg,
  input  logic [ptfr_pkg::PRIO_W-1:0] in_priority_threshold,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [ptfr_pkg::WORD_W-1:0] out_dispatch,
  output logic [ptfr_pkg::WORD_W-1:0] out_arg,
  output logic [ptfr_pkg::OCC_W-1:0]  out_occupancy,
  output logic                        out_last
);

  logic           cmd_valid;
  logic           cmd_pop;
  ptfr_pkg::cmd_t cmd;

  ptfr_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_action             (in_action),
    .in_dispatch_word      (in_dispatch_word),
    .in_task_arg           (in_task_arg),
    .in_priority_threshold (in_priority_threshold),
    .cmd_valid             (cmd_valid),
    .cmd                   (cmd),
    .cmd_pop               (cmd_pop)
  );

  ptfr_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_dispatch  (out_dispatch),
    .out_arg       (out_arg),
    .out_occupancy (out_occupancy),
    .out_last      (out_last)
  );

endmodule

[src/ptfr_front.sv]
// ---------------------------------------------------------------------------
// ptfr_front
// Accepts input transactions, classifies them and holds them in a
// two-entry command queue for the ring engine.
// ---------------------------------------------------------------------------
module ptfr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [ptfr_pkg::WORD_W-1:0] in_dispatch_word,
  input  logic [ptfr_pkg::WORD_W-1:0] in_task_arg,
  input  logic [ptfr_pkg::PRIO_W-1:0] in_priority_threshold,
  output logic                        cmd_valid,
  output ptfr_pkg::cmd_t              cmd,
  input  logic                        cmd_pop
);

  ptfr_pkg::cmd_t q_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  ptfr_pkg::cmd_t in_cmd;

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    in_cmd.is_drain      = (in_action == ptfr_pkg::ACT_DRAIN);
    in_cmd.dispatch_word = in_dispatch_word;
    in_cmd.task_arg      = in_task_arg;
    in_cmd.threshold     = in_priority_threshold;
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = cmd_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[src/ptfr_back.sv]
// ---------------------------------------------------------------------------
// ptfr_back
// Ring engine: entry memory, pointers, the scheduling drain sequencer and
// the output register.
// ---------------------------------------------------------------------------
module ptfr_back #(
  parameter int SLOTS = ptfr_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  ptfr_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [ptfr_pkg::WORD_W-1:0] out_dispatch,
  output logic [ptfr_pkg::WORD_W-1:0] out_arg,
  output logic [ptfr_pkg::OCC_W-1:0]  out_occupancy,
  output logic                        out_last
);

  localparam int PW = $clog2(SLOTS);
  localparam int EW = 2 * ptfr_pkg::WORD_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_EVAL  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  logic [EW-1:0] mem [SLOTS];
  logic [EW-1:0] rdata_r;

  state_t                      state_r, state_nxt;
  logic [PW-1:0]               wr_r, wr_nxt;
  logic [PW-1:0]               rd_r, rd_nxt;
  logic [PW-1:0]               skip_r, skip_nxt;
  logic [ptfr_pkg::PRIO_W-1:0] thr_r, thr_nxt;

  logic                        ov_r, ov_nxt;
  logic [1:0]                  st_r, st_nxt;
  logic [ptfr_pkg::WORD_W-1:0] od_r, od_nxt;
  logic [ptfr_pkg::WORD_W-1:0] oa_r, oa_nxt;
  logic [ptfr_pkg::OCC_W-1:0]  oc_r, oc_nxt;
  logic                        ol_r, ol_nxt;

  logic          out_free;
  logic          we;
  logic [EW-1:0] wdata;
  logic          rd_en;
  logic [PW-1:0] count;
  logic [PW-1:0] wr_inc, rd_inc;
  logic [PW:0]   wrap_sum;
  logic          full;
  logic [ptfr_pkg::PRIO_W-1:0] prio;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == PW'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_free = !ov_r || out_ready;
  assign wr_inc   = ring_next(wr_r);
  assign rd_inc   = ring_next(rd_r);
  assign full     = (wr_inc == rd_r);
  assign wrap_sum = {1'b0, wr_r} + (PW + 1)'(SLOTS) - {1'b0, rd_r};
  assign count    = (wr_r >= rd_r) ? (wr_r - rd_r) : wrap_sum[PW-1:0];
  assign prio     = rdata_r[EW-1-:ptfr_pkg::PRIO_W];

  always_comb begin
    state_nxt = state_r;
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    skip_nxt  = skip_r;
    thr_nxt   = thr_r;
    ov_nxt    = ov_r && !out_ready;
    st_nxt    = st_r;
    od_nxt    = od_r;
    oa_nxt    = oa_r;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    cmd_pop   = 1'b0;
    we        = 1'b0;
    wdata     = rdata_r;
    rd_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && cmd.is_drain) begin
          cmd_pop   = 1'b1;
          thr_nxt   = cmd.threshold;
          skip_nxt  = '0;
          state_nxt = S_CHECK;
        end else if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          ov_nxt  = 1'b1;
          od_nxt  = '0;
          oa_nxt  = '0;
          ol_nxt  = 1'b1;
          if (full) begin
            st_nxt = ptfr_pkg::ST_FULL;
            oc_nxt = ptfr_pkg::OCC_W'(count);
          end else begin
            we     = 1'b1;
            wdata  = {cmd.dispatch_word, cmd.task_arg};
            wr_nxt = wr_inc;
            st_nxt = ptfr_pkg::ST_ENQUEUED;
            oc_nxt = ptfr_pkg::OCC_W'(count + 1'b1);
          end
        end
      end
      S_CHECK: begin
        if (count == '0) begin
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_nxt    = rd_inc;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (prio <= thr_r) begin
          if (out_free) begin
            ov_nxt    = 1'b1;
            st_nxt    = ptfr_pkg::ST_DISPATCHED;
            od_nxt    = rdata_r[EW-1:ptfr_pkg::WORD_W];
            oa_nxt    = rdata_r[ptfr_pkg::WORD_W-1:0];
            oc_nxt    = ptfr_pkg::OCC_W'(count);
            ol_nxt    = 1'b0;
            skip_nxt  = '0;
            state_nxt = S_CHECK;
          end
        end else begin
          we     = 1'b1;
          wr_nxt = wr_inc;
          if (skip_r == PW'(SLOTS - 1)) begin
            skip_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            skip_nxt  = skip_r + 1'b1;
            state_nxt = S_CHECK;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          st_nxt    = ptfr_pkg::ST_DONE;
          od_nxt    = '0;
          oa_nxt    = '0;
          oc_nxt    = ptfr_pkg::OCC_W'(count);
          ol_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_r] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wr_r    <= '0;
      rd_r    <= '0;
      skip_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      skip_r  <= skip_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    thr_r <= thr_nxt;
    st_r  <= st_nxt;
    od_r  <= od_nxt;
    oa_r  <= oa_nxt;
    oc_r  <= oc_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_valid     = ov_r;
  assign out_status    = st_r;
  assign out_dispatch  = od_r;
  assign out_arg       = oa_r;
  assign out_occupancy = oc_r;
  assign out_last      = ol_r;

endmodule
